// File: rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Types and constants shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int COORD_W       = 15;
    localparam int DIFF_W        = 16;
    localparam int PROD_W        = 32;
    localparam int CROSS_W       = 33;
    localparam int NUM_W         = 49;
    localparam int REM_W         = 51;
    localparam int QUOT_W        = 18;
    localparam int TOLP_W        = 40;
    localparam int TOL_W         = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    localparam logic [1:0] SGN_ZERO = 2'd0;
    localparam logic [1:0] SGN_POS  = 2'd1;
    localparam logic [1:0] SGN_NEG  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] p1_x;
        logic [COORD_W-1:0] p1_y;
        logic [COORD_W-1:0] p2_x;
        logic [COORD_W-1:0] p2_y;
        logic [COORD_W-1:0] q1_x;
        logic [COORD_W-1:0] q1_y;
        logic [COORD_W-1:0] q2_x;
        logic [COORD_W-1:0] q2_y;
    } t_in;

    typedef struct packed {
        logic               touches;
        logic               has_point;
        logic [COORD_W-1:0] cross_x;
        logic [COORD_W-1:0] cross_y;
    } t_out;

    // per-item control and operands that ride alongside the dividers
    typedef struct packed {
        logic                     valid;
        logic                     touch;
        logic                     den_ok;
        logic                     neg_t;
        logic                     neg_u;
        logic signed [DIFF_W-1:0] rx;
        logic signed [DIFF_W-1:0] ry;
        logic [COORD_W-1:0]       p1x;
        logic [COORD_W-1:0]       p1y;
    } t_side;

    typedef struct packed {
        t_side               side;
        logic [NUM_W-1:0]    num_t;
        logic [NUM_W-1:0]    num_u;
        logic [CROSS_W-1:0]  den_mag;
    } t_front;

endpackage

`default_nettype wire

// File: rtl/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front
// Four stages: differences, products, cross sums, sign classification.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_front #(
    parameter int FRAC_BITS = sgi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire sgi_pkg::t_in                  i_data,
    input  wire logic [sgi_pkg::TOL_W-1:0]     i_tol,
    output sgi_pkg::t_front                    o_front
);

    localparam int DW = sgi_pkg::DIFF_W;
    localparam int PW = sgi_pkg::PROD_W;
    localparam int CW = sgi_pkg::CROSS_W;
    localparam int EW = sgi_pkg::TOLP_W;
    localparam int SH = 2 * FRAC_BITS - 16;

    // tolerance in product format and in coordinate format
    logic signed [EW-1:0] tolp;
    logic [sgi_pkg::TOL_W-1:0] tolc;

    generate
        if (SH >= 0) begin : g_tol_left
            assign tolp = EW'(i_tol) << SH;
        end else begin : g_tol_right
            localparam int RSH = 16 - 2 * FRAC_BITS;
            assign tolp = EW'(i_tol >> RSH);
        end
    endgenerate
    assign tolc = i_tol >> (16 - FRAC_BITS);

    function automatic logic [1:0] sgn(input logic signed [CW-1:0] v,
                                       input logic signed [EW-1:0] e);
        logic signed [EW-1:0] vx;
        vx = EW'(v);
        if (vx > e)       sgn = sgi_pkg::SGN_POS;
        else if (vx < -e) sgn = sgi_pkg::SGN_NEG;
        else              sgn = sgi_pkg::SGN_ZERO;
    endfunction

    function automatic logic in_box(input logic [14:0] a, input logic [14:0] b,
                                    input logic [14:0] c,
                                    input logic [sgi_pkg::TOL_W-1:0] e);
        logic [16:0] lo, hi, ce;
        lo = (a < b) ? 17'(a) : 17'(b);
        hi = (a < b) ? 17'(b) : 17'(a);
        ce = 17'(c) + 17'(e);
        in_box = (lo <= ce) && (17'(c) <= hi + 17'(e));
    endfunction

    function automatic logic signed [DW-1:0] dif(input logic [14:0] a,
                                                 input logic [14:0] b);
        dif = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // stage 1: differences and bounding checks
    logic r1_valid;
    logic signed [DW-1:0] r1_rx, r1_ry, r1_sx, r1_sy, r1_wx, r1_wy;
    logic signed [DW-1:0] r1_d2x, r1_d2y, r1_ex, r1_ey;
    logic [14:0] r1_p1x, r1_p1y;
    logic [3:0] r1_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_rx  <= dif(i_data.p2_x, i_data.p1_x);
            r1_ry  <= dif(i_data.p2_y, i_data.p1_y);
            r1_sx  <= dif(i_data.q2_x, i_data.q1_x);
            r1_sy  <= dif(i_data.q2_y, i_data.q1_y);
            r1_wx  <= dif(i_data.q1_x, i_data.p1_x);
            r1_wy  <= dif(i_data.q1_y, i_data.p1_y);
            r1_d2x <= dif(i_data.q2_x, i_data.p1_x);
            r1_d2y <= dif(i_data.q2_y, i_data.p1_y);
            r1_ex  <= dif(i_data.p2_x, i_data.q1_x);
            r1_ey  <= dif(i_data.p2_y, i_data.q1_y);
            r1_p1x <= i_data.p1_x;
            r1_p1y <= i_data.p1_y;
            r1_box[0] <= in_box(i_data.p1_x, i_data.p2_x, i_data.q1_x, tolc) &&
                         in_box(i_data.p1_y, i_data.p2_y, i_data.q1_y, tolc);
            r1_box[1] <= in_box(i_data.p1_x, i_data.p2_x, i_data.q2_x, tolc) &&
                         in_box(i_data.p1_y, i_data.p2_y, i_data.q2_y, tolc);
            r1_box[2] <= in_box(i_data.q1_x, i_data.q2_x, i_data.p1_x, tolc) &&
                         in_box(i_data.q1_y, i_data.q2_y, i_data.p1_y, tolc);
            r1_box[3] <= in_box(i_data.q1_x, i_data.q2_x, i_data.p2_x, tolc) &&
                         in_box(i_data.q1_y, i_data.q2_y, i_data.p2_y, tolc);
        end
    end

    // stage 2: products
    logic r2_valid;
    logic signed [PW-1:0] r2_m0, r2_m1, r2_m2, r2_m3, r2_m4;
    logic signed [PW-1:0] r2_m5, r2_m6, r2_m7, r2_m8, r2_m9;
    logic signed [DW-1:0] r2_rx, r2_ry;
    logic [14:0] r2_p1x, r2_p1y;
    logic [3:0] r2_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_m0  <= r1_rx * r1_wy;
            r2_m1  <= r1_ry * r1_wx;
            r2_m2  <= r1_rx * r1_d2y;
            r2_m3  <= r1_ry * r1_d2x;
            r2_m4  <= r1_sy * r1_wx;
            r2_m5  <= r1_sx * r1_wy;
            r2_m6  <= r1_sy * r1_ex;
            r2_m7  <= r1_sx * r1_ey;
            r2_m8  <= r1_rx * r1_sy;
            r2_m9  <= r1_ry * r1_sx;
            r2_rx  <= r1_rx;
            r2_ry  <= r1_ry;
            r2_p1x <= r1_p1x;
            r2_p1y <= r1_p1y;
            r2_box <= r1_box;
        end
    end

    // stage 3: cross products and denominator
    logic r3_valid;
    logic signed [CW-1:0] r3_c1, r3_c2, r3_c3, r3_c4, r3_den;
    logic signed [DW-1:0] r3_rx, r3_ry;
    logic [14:0] r3_p1x, r3_p1y;
    logic [3:0] r3_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_c1  <= CW'(r2_m0) - CW'(r2_m1);
            r3_c2  <= CW'(r2_m2) - CW'(r2_m3);
            r3_c3  <= CW'(r2_m4) - CW'(r2_m5);
            // orientation of p2 against q1-q2: sx * ey - sy * ex
            r3_c4  <= CW'(r2_m7) - CW'(r2_m6);
            r3_den <= CW'(r2_m8) - CW'(r2_m9);
            r3_rx  <= r2_rx;
            r3_ry  <= r2_ry;
            r3_p1x <= r2_p1x;
            r3_p1y <= r2_p1y;
            r3_box <= r2_box;
        end
    end

    // stage 4: tolerant signs, touch flag, divider operands
    logic [1:0] o1, o2, o3, o4;
    logic n_touch;
    logic signed [CW-1:0] un;
    logic [CW-1:0] absden, abst, absu;
    sgi_pkg::t_front n_front, r_front;

    always_comb begin
        o1 = sgn(r3_c1, tolp);
        o2 = sgn(r3_c2, tolp);
        o3 = sgn(r3_c3, tolp);
        o4 = sgn(r3_c4, tolp);
        n_touch = ((o1 != o2) && (o3 != o4)) ||
                  (o1 == sgi_pkg::SGN_ZERO && r3_box[0]) ||
                  (o2 == sgi_pkg::SGN_ZERO && r3_box[1]) ||
                  (o3 == sgi_pkg::SGN_ZERO && r3_box[2]) ||
                  (o4 == sgi_pkg::SGN_ZERO && r3_box[3]);
        un     = -r3_c1;
        absden = r3_den[CW-1] ? CW'(-r3_den) : CW'(r3_den);
        abst   = r3_c3[CW-1] ? CW'(-r3_c3) : CW'(r3_c3);
        absu   = un[CW-1] ? CW'(-un) : CW'(un);

        n_front.side.valid  = r3_valid;
        n_front.side.touch  = n_touch;
        n_front.side.den_ok = $signed({7'b0, absden}) > tolp;
        n_front.side.neg_t  = r3_c3[CW-1] ^ r3_den[CW-1];
        n_front.side.neg_u  = un[CW-1] ^ r3_den[CW-1];
        n_front.side.rx     = r3_rx;
        n_front.side.ry     = r3_ry;
        n_front.side.p1x    = r3_p1x;
        n_front.side.p1y    = r3_p1y;
        n_front.num_t       = {abst, 16'b0};
        n_front.num_u       = {absu, 16'b0};
        n_front.den_mag     = absden;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.side.valid <= 1'b0;
        end else if (i_en) begin
            r_front.side.valid <= n_front.side.valid;
        end
        if (i_en) begin
            r_front.side.touch  <= n_front.side.touch;
            r_front.side.den_ok <= n_front.side.den_ok;
            r_front.side.neg_t  <= n_front.side.neg_t;
            r_front.side.neg_u  <= n_front.side.neg_u;
            r_front.side.rx     <= n_front.side.rx;
            r_front.side.ry     <= n_front.side.ry;
            r_front.side.p1x    <= n_front.side.p1x;
            r_front.side.p1y    <= n_front.side.p1y;
            r_front.num_t       <= n_front.num_t;
            r_front.num_u       <= n_front.num_u;
            r_front.den_mag     <= n_front.den_mag;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

// File: rtl/sgi_divider.sv
// ----------------------------------------------------------------------------
// sgi_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [sgi_pkg::NUM_W-1:0]      i_num,
    input  wire logic [sgi_pkg::CROSS_W-1:0]    i_den,
    output logic [sgi_pkg::QUOT_W-1:0]          o_quot,
    output logic                                o_big
);

    localparam int QW = sgi_pkg::QUOT_W;
    localparam int RW = sgi_pkg::REM_W;
    localparam int DW = sgi_pkg::CROSS_W;

    logic [RW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_q    [0:QW-1];
    logic [DW-1:0] r_d    [0:QW-1];
    logic          r_big  [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            localparam int SH = QW - 1 - k;
            logic [RW-1:0] cur_rem;
            logic [QW-1:0] cur_q;
            logic [DW-1:0] cur_d;
            logic          cur_big;
            logic [RW-1:0] dsh;
            logic          ge;

            if (k == 0) begin : g_first
                assign cur_rem = RW'(i_num);
                assign cur_q   = '0;
                assign cur_d   = i_den;
                // quotient would need more than QW bits
                assign cur_big = (RW'(i_num) >> 16) >= (RW'(i_den) << 2);
            end else begin : g_next
                assign cur_rem = r_rem[k-1];
                assign cur_q   = r_q[k-1];
                assign cur_d   = r_d[k-1];
                assign cur_big = r_big[k-1];
            end

            assign dsh = RW'(cur_d) << SH;
            assign ge  = cur_rem >= dsh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? cur_rem - dsh : cur_rem;
                    r_q[k]   <= cur_q | (QW'(ge) << SH);
                    r_d[k]   <= cur_d;
                    r_big[k] <= cur_big;
                end
            end
        end
    endgenerate

    assign o_quot = r_q[QW-1];
    assign o_big  = r_big[QW-1];

endmodule

`default_nettype wire

// File: rtl/sgi_place.sv
// ----------------------------------------------------------------------------
// sgi_place
// Range check of t and u, point placement, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_place #(
    parameter int FRAC_BITS = sgi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire sgi_pkg::t_side                i_side,
    input  wire logic [sgi_pkg::QUOT_W-1:0]    i_qt,
    input  wire logic                          i_big_t,
    input  wire logic [sgi_pkg::QUOT_W-1:0]    i_qu,
    input  wire logic                          i_big_u,
    input  wire logic [sgi_pkg::TOL_W-1:0]     i_tol,
    output logic                               o_valid,
    output sgi_pkg::t_out                      o_data
);

    localparam int TW = sgi_pkg::QUOT_W + 2;
    localparam int MW = TW + sgi_pkg::DIFF_W;
    localparam int VW = 22;
    localparam logic signed [VW-1:0] COORD_MAX = VW'(100) <<< FRAC_BITS;

    logic signed [TW-1:0] t, u, lo, hi;
    logic in_t, in_u;

    always_comb begin
        t  = i_side.neg_t ? -$signed(TW'(i_qt)) : $signed(TW'(i_qt));
        u  = i_side.neg_u ? -$signed(TW'(i_qu)) : $signed(TW'(i_qu));
        lo = -$signed(TW'(i_tol));
        hi = $signed(TW'(65536)) + $signed(TW'(i_tol));
        in_t = !i_big_t && (t >= lo) && (t <= hi);
        in_u = !i_big_u && (u >= lo) && (u <= hi);
    end

    // stage a: scale r by t
    logic r_a_valid, r_a_touch, r_a_hit;
    logic signed [MW-1:0] r_a_px, r_a_py;
    logic [sgi_pkg::COORD_W-1:0] r_a_p1x, r_a_p1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_side.valid;
        end
        if (i_en) begin
            r_a_touch <= i_side.touch;
            r_a_hit   <= i_side.den_ok && in_t && in_u;
            r_a_px    <= MW'(t) * MW'(i_side.rx);
            r_a_py    <= MW'(t) * MW'(i_side.ry);
            r_a_p1x   <= i_side.p1x;
            r_a_p1y   <= i_side.p1y;
        end
    end

    // round half up, add base, clamp to the coordinate range
    function automatic logic [sgi_pkg::COORD_W-1:0] place(
        input logic [sgi_pkg::COORD_W-1:0] base,
        input logic signed [MW-1:0] prod);
        logic signed [MW:0] rnd;
        logic signed [VW-1:0] v;
        rnd = (MW+1)'(prod) + (MW+1)'(32768);
        v = $signed({1'b0, base}) + VW'(rnd >>> 16);
        if (v < 0)              v = '0;
        else if (v > COORD_MAX) v = COORD_MAX;
        place = v[sgi_pkg::COORD_W-1:0];
    endfunction

    logic r_out_valid;
    sgi_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_a_valid;
        end
        if (i_en) begin
            r_out.touches   <= r_a_touch;
            r_out.has_point <= r_a_hit;
            r_out.cross_x   <= r_a_hit ? place(r_a_p1x, r_a_px) : '0;
            r_out.cross_y   <= r_a_hit ? place(r_a_p1y, r_a_py) : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Orientation test and intersection point of two segments, fully pipelined.
// ----------------------------------------------------------------------------
// path from input transfer to result: front stages, divider stages, then placement stages
// throughput: one segment pair per cycle while o_stall is low, set by the bit-per-stage dividers
// a result refused by i_stall moves into an output register; the pipeline and
// o_stall hold only while that register is full
// reset: synchronous, clears all valid bits, tolerance returns to 1
`default_nettype none

module segment_intersection_unit #(
    parameter int FRAC_BITS = sgi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire sgi_pkg::t_in                  i_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output sgi_pkg::t_out                      o_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [sgi_pkg::TOL_W-1:0]     i_cfg_data
);

    localparam int QW = sgi_pkg::QUOT_W;

    logic [sgi_pkg::TOL_W-1:0] r_tol;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sgi_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // output register that catches a refused transfer
    logic          pipe_valid;
    sgi_pkg::t_out pipe_data;
    logic          r_hold_valid, n_hold_valid;
    sgi_pkg::t_out r_hold_data;

    assign n_hold_valid = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
        end
        if (!r_hold_valid) begin
            r_hold_data <= pipe_data;
        end
    end

    // advance unless the output register holds a result
    assign en      = !r_hold_valid;
    assign o_stall = r_hold_valid;
    assign o_valid = r_hold_valid || pipe_valid;
    assign o_data  = r_hold_valid ? r_hold_data : pipe_data;

    sgi_pkg::t_front front;

    sgi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_tol   (r_tol),
        .o_front (front)
    );

    logic [QW-1:0] qt, qu;
    logic big_t, big_u;

    sgi_divider u_div_t (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (front.num_t),
        .i_den  (front.den_mag),
        .o_quot (qt),
        .o_big  (big_t)
    );

    sgi_divider u_div_u (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (front.num_u),
        .i_den  (front.den_mag),
        .o_quot (qu),
        .o_big  (big_u)
    );

    // sideband delay matching the divider depth
    sgi_pkg::t_side r_side [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k] <= '0;
                end else if (en) begin
                    r_side[k] <= (k == 0) ? front.side : r_side[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    sgi_place #(.FRAC_BITS(FRAC_BITS)) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_side[QW-1]),
        .i_qt    (qt),
        .i_big_t (big_t),
        .i_qu    (qu),
        .i_big_u (big_u),
        .i_tol   (r_tol),
        .o_valid (pipe_valid),
        .o_data  (pipe_data)
    );

endmodule

`default_nettype wire

// File: tb/sgi_checker.sv
// ----------------------------------------------------------------------------
// sgi_checker
// Watches both channels of the segment intersection unit, predicts each
// result from the accepted segment pair and the current tolerance, and
// compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgi_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_in_stall,
    input  wire sgi_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire sgi_pkg::t_out i_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FB = sgi_pkg::FRAC_BITS_DEF;
    localparam longint COORD_TOP = longint'(100) << FB;

    logic [15:0]   tol;
    sgi_pkg::t_out expected_results[$];

    assign o_pending = expected_results.size();

    function automatic longint tol_prod();
        if (2 * FB >= 16) return longint'(tol) << (2 * FB - 16);
        return longint'(tol >> (16 - 2 * FB));
    endfunction

    function automatic int sgn(longint v);
        longint e;
        e = tol_prod();
        if (v > e) return 1;
        if (v < -e) return -1;
        return 0;
    endfunction

    function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic bit between(longint a, longint b, longint c);
        longint lo, hi, e;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        e  = longint'(tol >> (16 - FB));
        return (lo <= c + e) && (c <= hi + e);
    endfunction

    function automatic bit lies_on(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
        return sgn(orient(ax, ay, bx, by, cx, cy)) == 0 &&
               between(ax, bx, cx) && between(ay, by, cy);
    endfunction

    function automatic logic [14:0] locate(longint base, longint t, longint d);
        longint v, w;
        w = t * d + 32768;
        v = base + ((w >= 0) ? (w >>> 16) : -((-w + 65535) >>> 16));
        if (v < 0) v = 0;
        if (v > COORD_TOP) v = COORD_TOP;
        return v[14:0];
    endfunction

    function automatic sgi_pkg::t_out predict(sgi_pkg::t_in s);
        sgi_pkg::t_out r;
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint rx, ry, sx, sy, den, aden, wx, wy, t, u, e;
        int o1, o2, o3, o4;
        ax = s.p1_x; ay = s.p1_y; bx = s.p2_x; by = s.p2_y;
        cx = s.q1_x; cy = s.q1_y; dx = s.q2_x; dy = s.q2_y;
        o1 = sgn(orient(ax, ay, bx, by, cx, cy));
        o2 = sgn(orient(ax, ay, bx, by, dx, dy));
        o3 = sgn(orient(cx, cy, dx, dy, ax, ay));
        o4 = sgn(orient(cx, cy, dx, dy, bx, by));
        r = '0;
        if (o1 != o2 && o3 != o4) r.touches = 1'b1;
        else if (o1 == 0 && lies_on(ax, ay, bx, by, cx, cy)) r.touches = 1'b1;
        else if (o2 == 0 && lies_on(ax, ay, bx, by, dx, dy)) r.touches = 1'b1;
        else if (o3 == 0 && lies_on(cx, cy, dx, dy, ax, ay)) r.touches = 1'b1;
        else if (o4 == 0 && lies_on(cx, cy, dx, dy, bx, by)) r.touches = 1'b1;
        rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
        den  = rx * sy - ry * sx;
        aden = (den < 0) ? -den : den;
        if (aden > tol_prod()) begin
            wx = cx - ax; wy = cy - ay;
            // systemverilog division truncates toward zero like C
            t = ((wx * sy - wy * sx) * 65536) / den;
            u = ((wx * ry - wy * rx) * 65536) / den;
            e = tol;
            if (!(t < -e || t > 65536 + e || u < -e || u > 65536 + e)) begin
                r.has_point = 1'b1;
                r.cross_x   = locate(ax, t, rx);
                r.cross_y   = locate(ay, t, ry);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        sgi_pkg::t_out exp_r;
        if (!i_rst_n) begin
            tol <= 16'd1;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) tol <= i_cfg_data;
            if (i_valid && !i_in_stall) begin
                expected_results = {expected_results, predict(i_in_data)};
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.touches !== i_out_data.touches ||
                        exp_r.has_point !== i_out_data.has_point ||
                        exp_r.cross_x !== i_out_data.cross_x ||
                        exp_r.cross_y !== i_out_data.cross_y) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r,
                                 i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random segment pairs through the segment intersection
// unit across several tolerance settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 24;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    sgi_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    sgi_pkg::t_out out_data;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_data = '0;
    int            fail_count;
    int            pending;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_off = 1'b0;
    bit            done = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    segment_intersection_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_data(in_data), .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    sgi_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [14:0] coord(int mode);
        case (mode)
            0: return 15'($urandom_range(25600));
            1: return 15'($urandom_range(32767));
            2: return 15'($urandom_range(40) * 640);
            default: return 15'($urandom_range(12800, 12900));
        endcase
    endfunction

    function automatic sgi_pkg::t_in random_pair();
        sgi_pkg::t_in s;
        int m;
        m = $urandom_range(9);
        m = (m < 5) ? 0 : (m < 7) ? 2 : (m < 8) ? 3 : 1;
        s.p1_x = coord(m); s.p1_y = coord(m); s.p2_x = coord(m); s.p2_y = coord(m);
        s.q1_x = coord(m); s.q1_y = coord(m); s.q2_x = coord(m); s.q2_y = coord(m);
        // sometimes make the pair collinear or sharing an endpoint
        case ($urandom_range(7))
            0: begin s.q1_x = s.p1_x; s.q1_y = s.p1_y; end
            1: begin
                s.q1_x = s.p1_x; s.q1_y = s.p2_y;
                s.q2_x = s.p1_x; s.q2_y = s.p1_y;
                s.p2_x = s.p1_x;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic send(sgi_pkg::t_in s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [15:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic sgi_pkg::t_in make_pair(int a, int b, int c, int d, int e, int f,
                                               int g, int h);
        sgi_pkg::t_in s;
        s = {15'(a), 15'(b), 15'(c), 15'(d), 15'(e), 15'(f), 15'(g), 15'(h)};
        return s;
    endfunction

    initial begin
        logic [15:0] tols[6];
        tols = '{16'd1, 16'd0, 16'd65535, 16'd256, 16'd3000, 16'd1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: crossing, touching, parallel, collinear, extremes
        send(make_pair(0, 0, 25600, 25600, 0, 25600, 25600, 0));
        send(make_pair(0, 0, 25600, 0, 12800, 0, 12800, 25600));
        send(make_pair(0, 0, 25600, 0, 0, 256, 25600, 256));
        send(make_pair(0, 0, 12800, 0, 6400, 0, 25600, 0));
        send(make_pair(0, 0, 100, 0, 200, 0, 300, 0));
        send(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send(make_pair(32767, 32767, 0, 0, 0, 32767, 32767, 0));
        send(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send(make_pair(0, 0, 256, 256, 25600, 0, 0, 25600));
        send(make_pair(0, 0, 25600, 25600, 25600, 25600, 25600, 0));
        send(make_pair(0, 0, 25600, 1, 0, 1, 25600, 0));
        send(make_pair(0, 0, 25600, 0, 25601, 0, 25601, 100));
        send(make_pair(21845, 10922, 0, 32767, 10922, 21845, 32767, 0));
        send(make_pair(1, 1, 3, 2, 2, 1, 1, 3));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_tolerance(tols[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (phase == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 300; k++) send(random_pair());
            drain();
        end
        done = 1'b1;
    end

    initial begin
        wait (done);
        if (fail_count == 0) $display("segment_intersection_unit verification clean");
        else $display("segment_intersection_unit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("segment_intersection_unit verification failed");
        $finish;
    end
endmodule
